/* rtl/lav_pkg.sv */
// Shared types, widths and fixed-point helpers for the look-at view matrix.
// No dependencies; used by lav_unit and look_at_view_matrix.
`timescale 1ns / 1ps
package lav_pkg;

  localparam int IN_W      = 24;  // Q8.16 input coordinate
  localparam int UNIT_W    = 18;  // signed Q.16 unit component
  localparam int CX_W      = 42;  // signed vector fed to the normalizer
  localparam int MAG_W     = 41;  // magnitude of a CX_W value
  localparam int NRM_W     = 24;  // block-scaled magnitude
  localparam int SQ_W      = 50;  // sum of three squared magnitudes
  localparam int ROOT_W    = 25;
  localparam int REM_W     = 27;
  localparam int SQ_STEPS  = 25;
  localparam int DEN_W     = 26;
  localparam int QUO_W     = 17;
  localparam int DIV_STEPS = 17;
  localparam int PROD_W    = 42;  // Q8.16 times Q.16
  localparam int YP_W      = 36;  // Q.16 times Q.16
  localparam int DOT_W     = 44;
  localparam int OUT_W     = 32;
  localparam int UNIT_LAT  = 48;  // normalizer latency in cycles

  localparam logic [5:0]        NORM_POS = 6'd23;
  localparam logic [QUO_W-1:0]  ONE_Q    = 17'd65536;
  localparam logic [OUT_W-1:0]  ONE_Q16  = 32'h0001_0000;
  localparam logic [1:0]        ROW_LAST = 2'd3;

  typedef struct packed {
    logic [2:0][NRM_W-1:0] mag;
    logic [2:0]            sgn;
    logic                  zero;
  } lav_cargo_t;

  // Q8.16 coordinate times Q.16 unit component, exact.
  function automatic logic signed [PROD_W-1:0] mul_cu(logic signed [IN_W-1:0] a,
                                                      logic signed [UNIT_W-1:0] b);
    logic signed [PROD_W-1:0] ea, eb;
    ea = PROD_W'(a);
    eb = PROD_W'(b);
    return ea * eb;
  endfunction

  function automatic logic signed [YP_W-1:0] mul_uu(logic signed [UNIT_W-1:0] a,
                                                    logic signed [UNIT_W-1:0] b);
    logic signed [YP_W-1:0] ea, eb;
    ea = YP_W'(a);
    eb = YP_W'(b);
    return ea * eb;
  endfunction

  // Round half up to Q.16 and clamp to +-1.0.
  function automatic logic signed [UNIT_W-1:0] rnd_clamp(logic signed [YP_W:0] v);
    logic signed [YP_W:0] t;
    t = (v + (YP_W+1)'(32768)) >>> 16;
    if (t > (YP_W+1)'(65536))       return UNIT_W'(65536);
    else if (t < -(YP_W+1)'(65536)) return -UNIT_W'(65536);
    else                            return UNIT_W'(t);
  endfunction

  // Round half up to Q16.16, then negate.
  function automatic logic signed [OUT_W-1:0] rnd_neg(logic signed [DOT_W-1:0] v);
    logic signed [DOT_W-1:0] t;
    t = (v + DOT_W'(32768)) >>> 16;
    t = -t;
    return OUT_W'(t);
  endfunction

endpackage

/* rtl/lav_unit.sv */
// Pipelined vector normalizer: block scaling, squared length, bit-serial
// square root and restoring division, one stage per step. Uses lav_pkg.
`timescale 1ns / 1ps
module lav_unit (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [2:0][lav_pkg::CX_W-1:0]         vec,
  output logic [2:0][lav_pkg::UNIT_W-1:0]       unit
);
  import lav_pkg::*;

  // stage a: magnitudes and sign
  logic [2:0][MAG_W-1:0] mag_in;
  logic [2:0][MAG_W-1:0] mag_a;
  logic [2:0]            sgn_a;
  logic [MAG_W-1:0]      or_a;

  always_comb begin
    logic [CX_W-1:0] ng;
    for (int i = 0; i < 3; i++) begin
      ng = ~vec[i] + 1'b1;
      mag_in[i] = vec[i][CX_W-1] ? ng[MAG_W-1:0] : vec[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_a[i] <= mag_in[i];
        sgn_a[i] <= vec[i][CX_W-1];
      end
      or_a <= mag_in[0] | mag_in[1] | mag_in[2];
    end
  end

  // stage b: leading one of the largest magnitude
  logic [5:0]            lead;
  logic [5:0]            p_b;
  logic                  zero_b;
  logic [2:0][MAG_W-1:0] mag_b;
  logic [2:0]            sgn_b;

  always_comb begin
    lead = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (or_a[i]) lead = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_b    <= lead;
      zero_b <= (or_a == '0);
      mag_b  <= mag_a;
      sgn_b  <= sgn_a;
    end
  end

  // stage c: scale so the largest magnitude lies in [2^23, 2^24)
  lav_cargo_t cg_c_next, cg_c;

  always_comb begin
    logic [MAG_W-1:0] t;
    cg_c_next.sgn  = sgn_b;
    cg_c_next.zero = zero_b;
    for (int i = 0; i < 3; i++) begin
      if (p_b >= NORM_POS) t = mag_b[i] >> (p_b - NORM_POS);
      else                 t = mag_b[i] << (NORM_POS - p_b);
      cg_c_next.mag[i] = t[NRM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) cg_c <= cg_c_next;
  end

  // stage d: squares
  logic [2:0][2*NRM_W-1:0] sqr_d;
  lav_cargo_t              cg_d;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sqr_d[i] <= cg_c.mag[i] * cg_c.mag[i];
      cg_d <= cg_c;
    end
  end

  // square root, two radicand bits per stage
  logic [SQ_W-1:0]   sq_nm [0:SQ_STEPS];
  logic [REM_W-1:0]  sq_rm [0:SQ_STEPS];
  logic [ROOT_W-1:0] sq_rt [0:SQ_STEPS];
  lav_cargo_t        sq_cg [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_nm[0] <= SQ_W'(sqr_d[0]) + SQ_W'(sqr_d[1]) + SQ_W'(sqr_d[2]);
      sq_rm[0] <= '0;
      sq_rt[0] <= '0;
      sq_cg[0] <= cg_d;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W+1:0] trial, rem_sh;
    logic             ge;
    assign rem_sh = {sq_rm[k], sq_nm[k][SQ_W-1 -: 2]};
    assign trial  = {2'b00, sq_rt[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rm[k+1] <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        sq_rt[k+1] <= {sq_rt[k][ROOT_W-2:0], ge};
        sq_nm[k+1] <= {sq_nm[k][SQ_W-3:0], 2'b00};
        sq_cg[k+1] <= sq_cg[k];
      end
    end
  end

  // restoring division: q = (mag * 2^17 + s) / (2 s), one quotient bit per stage
  logic [DEN_W-1:0]            dv_d  [0:DIV_STEPS];
  logic [2:0][DEN_W-1:0]       dv_rm [0:DIV_STEPS];
  logic [2:0][DIV_STEPS-1:0]   dv_nl [0:DIV_STEPS];
  logic [2:0][QUO_W-1:0]       dv_q  [0:DIV_STEPS];
  lav_cargo_t                  dv_cg [0:DIV_STEPS];

  always_comb begin
    logic [CX_W-1:0] num;
    dv_d[0]  = {sq_rt[SQ_STEPS], 1'b0};
    dv_cg[0] = sq_cg[SQ_STEPS];
    for (int i = 0; i < 3; i++) begin
      num = {sq_cg[SQ_STEPS].mag[i], 17'd0} + CX_W'(sq_rt[SQ_STEPS]);
      dv_rm[0][i] = DEN_W'(num[CX_W-1:DIV_STEPS]);
      dv_nl[0][i] = num[DIV_STEPS-1:0];
      dv_q[0][i]  = '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [2:0][DEN_W:0]   r_sh;
    logic [2:0]            ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r_sh[i] = {dv_rm[k][i], dv_nl[k][i][DIV_STEPS-1]};
        ge[i]   = (r_sh[i] >= {1'b0, dv_d[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rm[k+1][i] <= ge[i] ? DEN_W'(r_sh[i] - {1'b0, dv_d[k]}) : DEN_W'(r_sh[i]);
          dv_nl[k+1][i] <= {dv_nl[k][i][DIV_STEPS-2:0], 1'b0};
          dv_q[k+1][i]  <= {dv_q[k][i][QUO_W-2:0], ge[i]};
        end
        dv_d[k+1]  <= dv_d[k];
        dv_cg[k+1] <= dv_cg[k];
      end
    end
  end

  // clamp, restore sign, force zero-length vectors to zero
  always_ff @(posedge clk) begin
    logic [QUO_W-1:0] qc;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qc = (dv_q[DIV_STEPS][i] > ONE_Q) ? ONE_Q : dv_q[DIV_STEPS][i];
        if (dv_cg[DIV_STEPS].zero)     unit[i] <= '0;
        else if (dv_cg[DIV_STEPS].sgn[i]) unit[i] <= -{1'b0, qc};
        else                           unit[i] <= {1'b0, qc};
      end
    end
  end

endmodule

/* rtl/look_at_view_matrix.sv */
// An accepted request passes the 103-stage pipeline and is loaded into the output
// register; row 0 is shown first, then rows 1-3 follow while the output is taken.
// The 4-row output register holds one matrix and sends it row by row; the
// pipeline itself advances one stage per cycle unless stalled.
// Reset clears the stage valid bits, the busy flag and the output row counter only.
// Uses lav_pkg and two lav_unit normalizers.
`timescale 1ns / 1ps
module look_at_view_matrix (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upward_x, upward_y, upward_z
  input  logic [215:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // col_zero, col_one, col_two, col_three
  output logic [127:0] m_tdata,
  // row_index
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);
  import lav_pkg::*;

  localparam int TOT = 2 * UNIT_LAT + 7;

  typedef struct packed {
    logic [2:0][IN_W-1:0] eye;
    logic [2:0][IN_W-1:0] up;
  } zside_t;

  typedef struct packed {
    logic [2:0][IN_W-1:0]   eye;
    logic [2:0][UNIT_W-1:0] zv;
  } xside_t;

  logic [TOT-1:0] vld;
  logic           en, load, take;
  logic           busy;
  logic [1:0]     row;

  assign take     = m_tvalid & m_tready;
  assign load     = vld[TOT-1] & (~busy | (take & (row == ROW_LAST)));
  assign en       = ~vld[TOT-1] | load;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], s_tvalid};
    end
  end

  // input register
  logic [2:0][IN_W-1:0] eye0, tgt0, up0;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye0[i] <= s_tdata[i*IN_W +: IN_W];
        tgt0[i] <= s_tdata[(3+i)*IN_W +: IN_W];
        up0[i]  <= s_tdata[(6+i)*IN_W +: IN_W];
      end
    end
  end

  // gaze axis
  logic [2:0][CX_W-1:0]   dvec;
  logic [2:0][UNIT_W-1:0] zv;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvec[i] = CX_W'(signed'(tgt0[i])) - CX_W'(signed'(eye0[i]));
    end
  end

  lav_unit u_zunit (.clk(clk), .en(en), .vec(dvec), .unit(zv));

  zside_t zdly [0:UNIT_LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      zdly[0] <= '{eye: eye0, up: up0};
      for (int i = 1; i < UNIT_LAT; i++) zdly[i] <= zdly[i-1];
    end
  end

  // up x Z
  logic signed [PROD_W-1:0] pp [6];
  logic [2:0][IN_W-1:0]     e49, e50;
  logic [2:0][UNIT_W-1:0]   z49, z50;
  logic [2:0][CX_W-1:0]     cx;

  always_ff @(posedge clk) begin
    logic [2:0][IN_W-1:0] u;
    u = zdly[UNIT_LAT-1].up;
    if (en) begin
      pp[0] <= mul_cu(u[1], zv[2]);
      pp[1] <= mul_cu(u[2], zv[1]);
      pp[2] <= mul_cu(u[2], zv[0]);
      pp[3] <= mul_cu(u[0], zv[2]);
      pp[4] <= mul_cu(u[0], zv[1]);
      pp[5] <= mul_cu(u[1], zv[0]);
      e49   <= zdly[UNIT_LAT-1].eye;
      z49   <= zv;
      cx[0] <= pp[0] - pp[1];
      cx[1] <= pp[2] - pp[3];
      cx[2] <= pp[4] - pp[5];
      e50   <= e49;
      z50   <= z49;
    end
  end

  // side axis
  logic [2:0][UNIT_W-1:0] xv;
  lav_unit u_xunit (.clk(clk), .en(en), .vec(cx), .unit(xv));

  xside_t xdly [0:UNIT_LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      xdly[0] <= '{eye: e50, zv: z50};
      for (int i = 1; i < UNIT_LAT; i++) xdly[i] <= xdly[i-1];
    end
  end

  // third axis and translation
  logic signed [YP_W-1:0]   yp [6];
  logic signed [PROD_W-1:0] dx [3], dz [3], dy [3];
  logic [2:0][IN_W-1:0]     e99, e100;
  logic [2:0][UNIT_W-1:0]   x99, z99, x100, z100, y100, x101, y101, z101;
  logic [2:0][UNIT_W-1:0]   fx, fy, fz;
  logic signed [OUT_W-1:0]  trx100, trz100, trx101, trz101, ft0, ft1, ft2;

  always_ff @(posedge clk) begin
    logic [2:0][IN_W-1:0]   e;
    logic [2:0][UNIT_W-1:0] z;
    e = xdly[UNIT_LAT-1].eye;
    z = xdly[UNIT_LAT-1].zv;
    if (en) begin
      yp[0] <= mul_uu(z[1], xv[2]);
      yp[1] <= mul_uu(z[2], xv[1]);
      yp[2] <= mul_uu(z[2], xv[0]);
      yp[3] <= mul_uu(z[0], xv[2]);
      yp[4] <= mul_uu(z[0], xv[1]);
      yp[5] <= mul_uu(z[1], xv[0]);
      for (int i = 0; i < 3; i++) begin
        dx[i] <= mul_cu(e[i], xv[i]);
        dz[i] <= mul_cu(e[i], z[i]);
      end
      e99 <= e;
      x99 <= xv;
      z99 <= z;

      y100[0] <= rnd_clamp((YP_W+1)'(yp[0]) - (YP_W+1)'(yp[1]));
      y100[1] <= rnd_clamp((YP_W+1)'(yp[2]) - (YP_W+1)'(yp[3]));
      y100[2] <= rnd_clamp((YP_W+1)'(yp[4]) - (YP_W+1)'(yp[5]));
      trx100  <= rnd_neg(DOT_W'(dx[0]) + DOT_W'(dx[1]) + DOT_W'(dx[2]));
      trz100  <= rnd_neg(DOT_W'(dz[0]) + DOT_W'(dz[1]) + DOT_W'(dz[2]));
      e100 <= e99;
      x100 <= x99;
      z100 <= z99;

      for (int i = 0; i < 3; i++) dy[i] <= mul_cu(e100[i], y100[i]);
      x101   <= x100;
      y101   <= y100;
      z101   <= z100;
      trx101 <= trx100;
      trz101 <= trz100;

      ft1 <= rnd_neg(DOT_W'(dy[0]) + DOT_W'(dy[1]) + DOT_W'(dy[2]));
      ft0 <= trx101;
      ft2 <= trz101;
      fx  <= x101;
      fy  <= y101;
      fz  <= z101;
    end
  end

  // output register: hold one matrix, send it row by row
  logic [2:0][UNIT_W-1:0]  ox, oy, oz;
  logic signed [OUT_W-1:0] ot0, ot1, ot2;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      row  <= '0;
    end else if (take) begin
      row <= row + 2'd1;
      if (row == ROW_LAST) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ox  <= fx;
      oy  <= fy;
      oz  <= fz;
      ot0 <= ft0;
      ot1 <= ft1;
      ot2 <= ft2;
    end
  end

  logic [OUT_W-1:0] c0, c1, c2, c3;
  always_comb begin
    case (row)
      2'd0: begin
        c0 = OUT_W'(signed'(ox[0]));
        c1 = OUT_W'(signed'(oy[0]));
        c2 = OUT_W'(signed'(oz[0]));
        c3 = '0;
      end
      2'd1: begin
        c0 = OUT_W'(signed'(ox[1]));
        c1 = OUT_W'(signed'(oy[1]));
        c2 = OUT_W'(signed'(oz[1]));
        c3 = '0;
      end
      2'd2: begin
        c0 = OUT_W'(signed'(ox[2]));
        c1 = OUT_W'(signed'(oy[2]));
        c2 = OUT_W'(signed'(oz[2]));
        c3 = '0;
      end
      default: begin
        c0 = ot0;
        c1 = ot1;
        c2 = ot2;
        c3 = ONE_Q16;
      end
    endcase
  end

  assign m_tvalid = busy;
  assign m_tdata  = {c3, c2, c1, c0};
  assign m_tuser  = row;
  assign m_tlast  = (row == ROW_LAST);

endmodule
